// ===== hdl/lmpd_pkg.sv =====
// lmpd_pkg: shared widths, register indexes and result types for the
// local-maximum peak detector. No dependencies.
package lmpd_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	localparam int SAMPLE_W    = 32;
	localparam int COORD_W     = 10;
	localparam int COUNT_W     = 19;
	localparam int DIM_W       = 11;
	localparam int BORDER_W    = 9;
	localparam int CFG_INDEX_W = 3;
	localparam int MIN_DIM     = 3;

	localparam int OUT_FIFO_DEPTH = 8;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_FRAME_WIDTH    = 3'd0,
		CFG_FRAME_HEIGHT   = 3'd1,
		CFG_BORDER_SIZE    = 3'd2,
		CFG_MIN_PEAK_LEVEL = 3'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] value;
		logic [COORD_W-1:0]         x;
		logic [COORD_W-1:0]         y;
		logic [COUNT_W-1:0]         count;
		logic                       frame_end;
	} peak_result_t;

	// Result pushes per cycle: first slot, then optional second slot.
	typedef struct packed {
		logic first;
		logic second;
	} push_t;

endpackage

// ===== hdl/lmpd_line_buf.sv =====
// lmpd_line_buf: single-port-write, single-read line memory holding the
// two previous rows per column. Uses lmpd_pkg.
module lmpd_line_buf #(
	parameter int DEPTH = lmpd_pkg::DEF_MAX_WIDTH,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                              clk,
	input  logic                              rd_en,
	input  logic [AW-1:0]                     rd_addr,
	output logic [2*lmpd_pkg::SAMPLE_W-1:0]   rd_data,
	input  logic                              wr_en,
	input  logic [AW-1:0]                     wr_addr,
	input  logic [2*lmpd_pkg::SAMPLE_W-1:0]   wr_data
);
	import lmpd_pkg::*;

	logic [2*SAMPLE_W-1:0] mem [DEPTH];
	logic [2*SAMPLE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/lmpd_out_fifo.sv =====
// lmpd_out_fifo: small result queue taking up to two results per cycle.
// Uses lmpd_pkg (peak_result_t, push_t).
module lmpd_out_fifo #(
	parameter int DEPTH = lmpd_pkg::OUT_FIFO_DEPTH,
	parameter int PW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lmpd_pkg::push_t         push,
	input  lmpd_pkg::peak_result_t  push_data_first,
	input  lmpd_pkg::peak_result_t  push_data_second,
	input  logic                    pop,
	output lmpd_pkg::peak_result_t  head,
	output logic                    not_empty,
	output logic [CW-1:0]           level
);
	import lmpd_pkg::*;

	peak_result_t  mem [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] level_q;
	logic [PW-1:0] wr_ptr_inc;
	logic [PW-1:0] wr_ptr_inc2;
	logic [PW-1:0] rd_ptr_inc;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		ptr_next = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign wr_ptr_inc  = ptr_next(wr_ptr_q);
	assign wr_ptr_inc2 = ptr_next(wr_ptr_inc);
	assign rd_ptr_inc  = ptr_next(rd_ptr_q);

	always_ff @(posedge clk) begin
		if (push.first) begin
			mem[wr_ptr_q] <= push_data_first;
		end
		if (push.second) begin
			mem[wr_ptr_inc] <= push_data_second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push.first && push.second) begin
				wr_ptr_q <= wr_ptr_inc2;
			end else if (push.first) begin
				wr_ptr_q <= wr_ptr_inc;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_inc;
			end
			level_q <= level_q + CW'(push.first) + CW'(push.second) - CW'(pop);
		end
	end

	assign head      = mem[rd_ptr_q];
	assign not_empty = (level_q != '0);
	assign level     = level_q;

endmodule

// ===== hdl/local_max_peak_detector_top.sv =====
// local_max_peak_detector_top: 3x3 peak detector (lmpd_pkg, lmpd_line_buf, lmpd_out_fifo).
// Results of a sample are queued from stage 1 (a peak on the last sample is queued along
//   with the frame-end result, peak first). Throughput: 1 sample per cycle, set by the
//   registered line-buffer read; input stalls only when the 8-entry result queue is near
//   full. Reset (arst_n, async, low): counters, window, queue cleared, config to defaults;
//   line buffers are not cleared (stale entries only land in window rows that are never tested).
module local_max_peak_detector_top #(
	parameter int MAX_WIDTH  = lmpd_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = lmpd_pkg::DEF_MAX_HEIGHT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [lmpd_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [lmpd_pkg::SAMPLE_W-1:0]        cfg_data,
	// sample stream
	input  logic                                 snr_valid,
	output logic                                 snr_stall,
	input  logic signed [lmpd_pkg::SAMPLE_W-1:0] snr_sample,
	// result stream
	output logic                                 peak_valid,
	input  logic                                 peak_stall,
	output logic signed [lmpd_pkg::SAMPLE_W-1:0] peak_value,
	output logic [lmpd_pkg::COORD_W-1:0]         peak_x,
	output logic [lmpd_pkg::COORD_W-1:0]         peak_y,
	output logic [lmpd_pkg::COUNT_W-1:0]         peak_count,
	output logic                                 frame_end
);
	import lmpd_pkg::*;

	localparam int XW  = $clog2(MAX_WIDTH);
	localparam int YW  = $clog2(MAX_HEIGHT);
	// geometry compare width: holds the clamped dimensions and the raw register
	localparam int DW0 = (XW + 1 > YW + 1) ? XW + 1 : YW + 1;
	localparam int DW  = (DW0 > DIM_W) ? DW0 : DIM_W;
	localparam int GW  = DW + 1;
	localparam int FIFO_CW = $clog2(OUT_FIFO_DEPTH + 1);

	// ---------------- configuration registers ----------------
	logic [DIM_W-1:0]           frame_width_q;
	logic [DIM_W-1:0]           frame_height_q;
	logic [BORDER_W-1:0]        border_size_q;
	logic signed [SAMPLE_W-1:0] min_level_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= DIM_W'(1024);
			frame_height_q <= DIM_W'(1024);
			border_size_q  <= BORDER_W'(1);
			min_level_q    <= {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FRAME_WIDTH:    frame_width_q  <= cfg_data[DIM_W-1:0];
				CFG_FRAME_HEIGHT:   frame_height_q <= cfg_data[DIM_W-1:0];
				CFG_BORDER_SIZE:    border_size_q  <= cfg_data[BORDER_W-1:0];
				CFG_MIN_PEAK_LEVEL: min_level_q    <= signed'(cfg_data);
				default: ;  // unknown index: ignored
			endcase
		end
	end

	// Clamp geometry to [3, MAX]; a zero border acts as one.
	logic [DW-1:0]     fw_ext, fh_ext, w_dim, h_dim;
	logic [BORDER_W-1:0] b_eff;

	assign fw_ext = DW'(frame_width_q);
	assign fh_ext = DW'(frame_height_q);

	always_comb begin
		if (fw_ext < DW'(MIN_DIM))        w_dim = DW'(MIN_DIM);
		else if (fw_ext > DW'(MAX_WIDTH)) w_dim = DW'(MAX_WIDTH);
		else                              w_dim = fw_ext;
		if (fh_ext < DW'(MIN_DIM))         h_dim = DW'(MIN_DIM);
		else if (fh_ext > DW'(MAX_HEIGHT)) h_dim = DW'(MAX_HEIGHT);
		else                               h_dim = fh_ext;
	end

	assign b_eff = (border_size_q == '0) ? BORDER_W'(1) : border_size_q;

	// ---------------- stage 0: raster position, line-buffer read ----------------
	logic          accept;
	logic [XW-1:0] col_q;
	logic [YW-1:0] row_q;
	logic          row_last, frame_last;

	assign accept     = snr_valid && !snr_stall;
	assign row_last   = (DW'(col_q) + DW'(1)) >= w_dim;
	assign frame_last = row_last && ((DW'(row_q) + DW'(1)) >= h_dim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_last) begin
				col_q <= '0;
				row_q <= frame_last ? '0 : row_q + YW'(1);
			end else begin
				col_q <= col_q + XW'(1);
			end
		end
	end

	// ---------------- stage 1: window test and result push ----------------
	logic                       v_s1;
	logic [XW-1:0]              col_s1;
	logic [YW-1:0]              row_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic                       last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1    <= col_q;
			row_s1    <= row_q;
			sample_s1 <= snr_sample;
			last_s1   <= frame_last;
		end
	end

	// Line buffer word is {two rows above, one row above}; read at accept,
	// rewritten in the cycle after with the rows shifted down.
	logic [2*SAMPLE_W-1:0]      lb_rd_data;
	logic signed [SAMPLE_W-1:0] lb_top, lb_mid;

	lmpd_line_buf #(
		.DEPTH (MAX_WIDTH),
		.AW    (XW)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (lb_rd_data),
		.wr_en   (v_s1),
		.wr_addr (col_s1),
		.wr_data ({lb_mid, sample_s1})
	);

	assign lb_top = signed'(lb_rd_data[2*SAMPLE_W-1:SAMPLE_W]);
	assign lb_mid = signed'(lb_rd_data[SAMPLE_W-1:0]);

	// 3x3 window: entries 0..2 left column, 3..5 middle column, newest column
	// comes straight from the line buffer and the incoming sample.
	logic signed [SAMPLE_W-1:0] win_q [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (v_s1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= lb_top;
			win_q[4] <= lb_mid;
			win_q[5] <= sample_s1;
		end
	end

	logic signed [SAMPLE_W-1:0] center;
	logic [GW-1:0]              cx, cy, b_ext;
	logic                       pos_ok, border_ok, all_greater, level_ok, is_peak, end_push;

	assign center = win_q[4];
	assign cx     = GW'(col_s1) - GW'(1);
	assign cy     = GW'(row_s1) - GW'(1);
	assign b_ext  = GW'(b_eff);

	assign pos_ok    = (col_s1 >= XW'(2)) && (row_s1 >= YW'(2));
	assign border_ok = (cx >= b_ext) && ((cx + b_ext) < GW'(w_dim)) &&
	                   (cy >= b_ext) && ((cy + b_ext) < GW'(h_dim));
	// strict: any neighbor equal to the center kills the peak
	assign all_greater = (center > win_q[0]) && (center > win_q[1]) &&
	                     (center > win_q[2]) && (center > win_q[3]) &&
	                     (center > win_q[5]) && (center > lb_top) &&
	                     (center > lb_mid)   && (center > sample_s1);
	assign level_ok = (center >= min_level_q);
	assign is_peak  = v_s1 && pos_ok && border_ok && all_greater && level_ok;
	assign end_push = v_s1 && last_s1;

	// running peak index within the frame
	logic [COUNT_W-1:0] peaks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peaks_q <= '0;
		end else if (end_push) begin
			peaks_q <= '0;
		end else if (is_peak) begin
			peaks_q <= peaks_q + COUNT_W'(1);
		end
	end

	peak_result_t peak_res, end_res, push_first_data;
	push_t        push;

	always_comb begin
		peak_res.value     = center;
		peak_res.x         = cx[COORD_W-1:0];
		peak_res.y         = cy[COORD_W-1:0];
		peak_res.count     = peaks_q;
		peak_res.frame_end = 1'b0;

		end_res.value      = '0;
		end_res.x          = '0;
		end_res.y          = '0;
		end_res.count      = is_peak ? peaks_q + COUNT_W'(1) : peaks_q;
		end_res.frame_end  = 1'b1;
	end

	// a peak on the last sample goes out ahead of the frame summary
	assign push.first      = is_peak || end_push;
	assign push.second     = is_peak && end_push;
	assign push_first_data = is_peak ? peak_res : end_res;

	// ---------------- result queue ----------------
	peak_result_t       head;
	logic               fifo_not_empty;
	logic [FIFO_CW-1:0] fifo_level;
	logic [FIFO_CW:0]   fifo_commit;

	lmpd_out_fifo #(
		.DEPTH (OUT_FIFO_DEPTH)
	) u_out_fifo (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.push_data_first  (push_first_data),
		.push_data_second (end_res),
		.pop              (peak_valid && !peak_stall),
		.head             (head),
		.not_empty        (fifo_not_empty),
		.level            (fifo_level)
	);

	// Reserve room for two results of the sample in flight plus two for a new one.
	assign fifo_commit = {1'b0, fifo_level} + (v_s1 ? (FIFO_CW+1)'(2) : '0);
	assign snr_stall   = fifo_commit > (FIFO_CW+1)'(OUT_FIFO_DEPTH - 2);

	assign peak_valid = fifo_not_empty;
	assign peak_value = head.value;
	assign peak_x     = head.x;
	assign peak_y     = head.y;
	assign peak_count = head.count;
	assign frame_end  = head.frame_end;

	// ---------------- assertions ----------------
	a_queue_reserve: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_commit <= (FIFO_CW+1)'(OUT_FIFO_DEPTH))
		else $error("result queue reservation exceeded");

	a_stage_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> $past(snr_valid && !snr_stall))
		else $error("stage 1 valid without a sample transaction");

	a_summary_zeroed: assert property (@(posedge clk) disable iff (!arst_n)
		(peak_valid && frame_end) |-> (peak_value == '0 && peak_x == '0 && peak_y == '0))
		else $error("frame-end result carries peak data");

endmodule

// ===== tb/tb.sv =====
// tb: self-checking testbench for local_max_peak_detector_top (3x3 strict local maxima).
// Raster frames go in through a queue-fed driver; a monitor checks each result transaction
// against a predictor kept here. Depends on lmpd_pkg and the detector RTL.
`timescale 1ns / 1ps

module tb;
	import lmpd_pkg::*;

	localparam int CYCLE_LIMIT    = 2_000_000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int SAMPLE_TARGET  = 1650;
	localparam int MAX_DIM_W      = DEF_MAX_WIDTH;
	localparam int MAX_DIM_H      = DEF_MAX_HEIGHT;

	// config indexes past the four real registers; writes there must be dropped
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

	localparam logic signed [SAMPLE_W-1:0] MASKED_CODE = 32'sh8000_0000;
	localparam logic signed [SAMPLE_W-1:0] MAX_CODE    = 32'sh7FFF_FFFF;

	typedef enum int {
		DATA_RANDOM,
		DATA_TIES,
		DATA_SPARSE,
		DATA_EXTREME
	} data_mode_t;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_INDEX_W-1:0]     cfg_index = '0;
	logic [SAMPLE_W-1:0]        cfg_data = '0;
	logic                       snr_valid = 1'b0;
	logic                       snr_stall;
	logic signed [SAMPLE_W-1:0] snr_sample = '0;
	logic                       peak_valid;
	logic                       peak_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] peak_value;
	logic [COORD_W-1:0]         peak_x;
	logic [COORD_W-1:0]         peak_y;
	logic [COUNT_W-1:0]         peak_count;
	logic                       frame_end;

	local_max_peak_detector_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.snr_valid  (snr_valid),
		.snr_stall  (snr_stall),
		.snr_sample (snr_sample),
		.peak_valid (peak_valid),
		.peak_stall (peak_stall),
		.peak_value (peak_value),
		.peak_x     (peak_x),
		.peak_y     (peak_y),
		.peak_count (peak_count),
		.frame_end  (frame_end)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Register copy, updated on each accepted config transaction
	// ---------------------------------------------------------------
	logic [DIM_W-1:0]           reg_width  = 11'd1024;
	logic [DIM_W-1:0]           reg_height = 11'd1024;
	logic [BORDER_W-1:0]        reg_border = 9'd1;
	logic signed [SAMPLE_W-1:0] reg_level  = MASKED_CODE;

	// ---------------------------------------------------------------
	// Peak predictor state: two line stores, 3x3 window, raster position
	// ---------------------------------------------------------------
	logic signed [SAMPLE_W-1:0] line_above [MAX_DIM_W];
	logic signed [SAMPLE_W-1:0] line_two_above [MAX_DIM_W];
	logic signed [SAMPLE_W-1:0] window [6];
	int                         pos_col = 0;
	int                         pos_row = 0;
	logic [COUNT_W-1:0]         peaks_in_frame = '0;

	peak_result_t               expected_peaks [$];
	logic signed [SAMPLE_W-1:0] pending_samples [$];

	int cycle_count    = 0;
	int mismatches     = 0;
	int samples_taken  = 0;
	int results_seen   = 0;
	int frames_done    = 0;
	int reg_writes     = 0;
	int samples_queued = 0;

	function automatic int clamp_dim(input int v, input int maxv);
		if (v < MIN_DIM)
			return MIN_DIM;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	// One accepted sample: test the pixel up-left of it, shift window and
	// line stores, advance the raster position, emit frame summary at the end.
	task automatic predict_sample(input logic signed [SAMPLE_W-1:0] s);
		int                         w, h, b, cx, cy;
		logic signed [SAMPLE_W-1:0] top, mid, ctr;
		bit                         is_peak;
		peak_result_t               res;
		w = clamp_dim(reg_width, MAX_DIM_W);
		h = clamp_dim(reg_height, MAX_DIM_H);
		b = (reg_border == 0) ? 1 : reg_border;
		top = line_two_above[pos_col];
		mid = line_above[pos_col];
		if (pos_col >= 2 && pos_row >= 2) begin
			cx = pos_col - 1;
			cy = pos_row - 1;
			ctr = window[4];
			is_peak = 1'b1;
			for (int i = 0; i < 6; i++)
				if (i != 4 && window[i] >= ctr)
					is_peak = 1'b0;
			if (top >= ctr || mid >= ctr || s >= ctr)
				is_peak = 1'b0;
			if (cx < b || cx + b >= w || cy < b || cy + b >= h)
				is_peak = 1'b0;
			if (ctr < reg_level)
				is_peak = 1'b0;
			if (is_peak) begin
				res.value = ctr;
				res.x = COORD_W'(cx);
				res.y = COORD_W'(cy);
				res.count = peaks_in_frame;
				res.frame_end = 1'b0;
				expected_peaks.push_back(res);
				peaks_in_frame = peaks_in_frame + 1'b1;
			end
		end
		line_two_above[pos_col] = mid;
		line_above[pos_col] = s;
		window[0] = window[3];
		window[1] = window[4];
		window[2] = window[5];
		window[3] = top;
		window[4] = mid;
		window[5] = s;
		if (pos_col + 1 >= w) begin
			pos_col = 0;
			if (pos_row + 1 >= h) begin
				res.value = '0;
				res.x = '0;
				res.y = '0;
				res.count = peaks_in_frame;
				res.frame_end = 1'b1;
				expected_peaks.push_back(res);
				pos_row = 0;
				peaks_in_frame = '0;
				frames_done++;
			end else begin
				pos_row++;
			end
		end else begin
			pos_col++;
		end
	endtask

	// ---------------------------------------------------------------
	// Sample driver: bursts of random length, random gaps, calm stretches
	// ---------------------------------------------------------------
	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk) begin : sample_driver
		logic                       present;
		logic signed [SAMPLE_W-1:0] next_sample;
		present = 1'b0;
		next_sample = snr_sample;
		if (arst_n) begin
			if (snr_valid && !snr_stall) begin
				predict_sample(snr_sample);
				samples_taken++;
			end
			// slot is free: either nothing was offered or it was just taken
			if (!snr_valid || !snr_stall) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_samples.size() > 0) begin
					present = 1'b1;
					next_sample = pending_samples.pop_front();
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 32);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
				snr_valid <= present;
				snr_sample <= next_sample;
			end
		end
	end

	// ---------------------------------------------------------------
	// Result stall pattern, in one of four randomly chosen modes
	// ---------------------------------------------------------------
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_hold = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_hold == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				stall_hold = $urandom_range(100, 500);
			end else begin
				stall_hold--;
			end
			case (stall_mode)
				STALL_NONE:     peak_stall <= 1'b0;
				STALL_LIGHT:    peak_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY:    peak_stall <= ($urandom_range(0, 3) != 0);
				default:        peak_stall <= cycle_count[4];
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Result monitor: compare each transaction with the oldest expectation
	// ---------------------------------------------------------------
	always @(posedge clk) begin : result_monitor
		peak_result_t want;
		if (arst_n && peak_valid && !peak_stall) begin
			results_seen++;
			if (expected_peaks.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: unexpected result value=%h x=%0d y=%0d count=%0d end=%b",
						$realtime, peak_value, peak_x, peak_y, peak_count, frame_end);
				mismatches++;
			end else begin
				want = expected_peaks.pop_front();
				if (peak_value !== want.value || peak_x !== want.x || peak_y !== want.y ||
						peak_count !== want.count || frame_end !== want.frame_end) begin
					if (mismatches < 10)
						$display("%0t: mismatch exp value=%h x=%0d y=%0d count=%0d end=%b | got value=%h x=%0d y=%0d count=%0d end=%b",
							$realtime, want.value, want.x, want.y, want.count,
							want.frame_end, peak_value, peak_x, peak_y, peak_count,
							frame_end);
					mismatches++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout: %0d cycles, %0d results still expected", cycle_count,
				expected_peaks.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	function automatic logic signed [SAMPLE_W-1:0] gen_sample(input data_mode_t m);
		case (m)
			DATA_TIES:    return 32'($urandom_range(0, 4)) - 32'd2;
			DATA_SPARSE:  return ($urandom_range(0, 5) == 0) ? ($urandom() >> 1) : MASKED_CODE;
			DATA_EXTREME: begin
				case ($urandom_range(0, 4))
					0:       return MASKED_CODE;
					1:       return MAX_CODE;
					2:       return '0;
					3:       return '1;
					default: return $urandom();
				endcase
			end
			default:      return $urandom();
		endcase
	endfunction

	// Sender idle and every expected result in; then let the pipe settle.
	// Leaves the caller on a rising edge, ready for config writes.
	task automatic wait_idle();
		while (pending_samples.size() > 0 || snr_valid || expected_peaks.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Caller is on a rising edge; returns on the edge of the accepted transaction.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [SAMPLE_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_FRAME_WIDTH:    reg_width = data[DIM_W-1:0];
			CFG_FRAME_HEIGHT:   reg_height = data[DIM_W-1:0];
			CFG_BORDER_SIZE:    reg_border = data[BORDER_W-1:0];
			CFG_MIN_PEAK_LEVEL: reg_level = data;
			default:            ;
		endcase
		reg_writes++;
	endtask

	task automatic queue_samples(input int n, input data_mode_t m);
		for (int i = 0; i < n; i++)
			pending_samples.push_back(gen_sample(m));
		samples_queued += n;
	endtask

	// Reprogram all four registers at a frame boundary and queue whole frames.
	task automatic run_phase(input int w, input int h, input int border,
			input logic signed [SAMPLE_W-1:0] level, input int frames, input data_mode_t m);
		wait_idle();
		write_reg(CFG_FRAME_WIDTH, w);
		write_reg(CFG_FRAME_HEIGHT, h);
		write_reg(CFG_BORDER_SIZE, border);
		write_reg(CFG_MIN_PEAK_LEVEL, level);
		cfg_valid <= 1'b0;
		queue_samples(frames * clamp_dim(reg_width, MAX_DIM_W) *
			clamp_dim(reg_height, MAX_DIM_H), m);
	endtask

	// 3x3 frame: center at the middle, last sample (bottom right) separate
	task automatic push_square(input logic signed [SAMPLE_W-1:0] ctr,
			input logic signed [SAMPLE_W-1:0] around, input logic signed [SAMPLE_W-1:0] last);
		for (int i = 0; i < 8; i++)
			pending_samples.push_back(i == 4 ? ctr : around);
		pending_samples.push_back(last);
		samples_queued += 9;
	endtask

	// Feed samples until the predictor's raster position wraps to a new frame.
	// Only valid with the predictor caught up (after wait_idle).
	task automatic finish_frame(input data_mode_t m);
		int c, r, w, h, n;
		w = clamp_dim(reg_width, MAX_DIM_W);
		h = clamp_dim(reg_height, MAX_DIM_H);
		c = pos_col;
		r = pos_row;
		n = 0;
		forever begin
			n++;
			if (c + 1 < w)
				c++;
			else if (r + 1 < h) begin
				c = 0;
				r++;
			end else
				break;
		end
		queue_samples(n, m);
	endtask

	// Partial frame, then shrink width and change height in mid-frame, then
	// finish. Width never grows mid-frame, so no unwritten line entry is read.
	task automatic run_cut_phase(input int w, input int h, input data_mode_t m);
		run_phase(w, h, $urandom_range(1, 2), MASKED_CODE, 0, m);
		queue_samples($urandom_range(1, w * h - 1), m);
		wait_idle();
		write_reg(CFG_FRAME_WIDTH, $urandom_range(MIN_DIM, w));
		write_reg(CFG_FRAME_HEIGHT, $urandom_range(MIN_DIM, h + 3));
		cfg_valid <= 1'b0;
		finish_frame(m);
	endtask

	// ---------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------
	initial begin : stimulus
		int         w, h, border, frames, prev_queued;
		logic signed [SAMPLE_W-1:0] level;
		data_mode_t m;

		for (int i = 0; i < MAX_DIM_W; i++) begin
			line_above[i] = '0;
			line_two_above[i] = '0;
		end
		for (int i = 0; i < 6; i++)
			window[i] = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// spare indexes must leave the real registers alone
		wait_idle();
		write_reg(CFG_SPARE_LO, '1);
		write_reg(CFG_SPARE_HI, '0);
		cfg_valid <= 1'b0;

		// border 0 acts as 1; top code amid masked pixels, found on the last
		// sample so peak and frame summary come from one transaction
		run_phase(3, 3, 0, MASKED_CODE, 0, DATA_RANDOM);
		push_square(MAX_CODE, MASKED_CODE, MASKED_CODE);
		// peak exactly at the level cut is kept
		run_phase(3, 3, 1, 32'sd100, 0, DATA_RANDOM);
		push_square(32'sd100, 32'sd99, 32'sd99);
		// undersized geometry clamps to 3x3; a tie with the newest sample kills the peak
		run_phase(0, 2, 1, MASKED_CODE, 0, DATA_RANDOM);
		push_square(32'sd0, -32'sd1, 32'sd0);

		// oversized width code clamps to the maximum: one full row plus a bit,
		// then the width shrinks in mid-frame so the frame ends soon
		run_phase(2047, 3, 1, MASKED_CODE, 0, DATA_RANDOM);
		queue_samples(MAX_DIM_W + 2, DATA_RANDOM);
		wait_idle();
		write_reg(CFG_FRAME_WIDTH, MIN_DIM);
		cfg_valid <= 1'b0;
		finish_frame(DATA_RANDOM);

		// random phases: mostly whole frames, some mid-frame geometry cuts
		while (samples_queued < SAMPLE_TARGET) begin
			prev_queued = samples_queued;
			m = data_mode_t'($urandom_range(0, 3));
			if ($urandom_range(0, 7) == 0) begin
				run_cut_phase($urandom_range(4, 12), $urandom_range(4, 10), m);
			end else begin
				w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) :
					$urandom_range(MIN_DIM, ($urandom_range(0, 3) == 0) ? 40 : 10);
				h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) :
					$urandom_range(MIN_DIM, 10);
				case ($urandom_range(0, 9))
					0:       border = 0;
					1:       border = $urandom_range(5, 511);
					default: border = $urandom_range(1, 3);
				endcase
				case ($urandom_range(0, 7))
					0, 1:    level = $urandom();
					2:       level = '0;
					3:       level = MAX_CODE;
					default: level = MASKED_CODE;
				endcase
				frames = $urandom_range(1, 3);
				run_phase(w, h, border, level, frames, m);
			end
			if (samples_queued == prev_queued)
				break;
		end

		wait_idle();
		repeat (8) @(posedge clk);

		$display("covered %0d samples in %0d frames, %0d result transactions, %0d reg writes",
			samples_taken, frames_done, results_seen, reg_writes);
		$display("geometries 3x3 up to 1024 wide, clamping, mid-frame cuts, borders 0..511, level cuts");
		if (mismatches == 0 && expected_peaks.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d results never seen", mismatches,
				expected_peaks.size());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/lmpd_pkg.sv
hdl/lmpd_line_buf.sv
hdl/lmpd_out_fifo.sv
hdl/local_max_peak_detector_top.sv
tb/tb.sv
